[rtl/core/ffca_pkg.sv]
// Shared types, sizes and codes for the first-fit coalescing allocator.
// Used by the segment cell, the segment chain and the top level.
package ffca_pkg;

  localparam int MAX_SEGMENTS      = 32;
  localparam int MAX_RECORDS       = 32;
  localparam int HEADER_BYTES      = 16;
  localparam int HEADER_ALIGN      = 8;
  localparam int SEGMENT_ALIGN     = 8;
  localparam int MIN_SEGMENT_BYTES = 32;

  localparam int SEG_IDX_W = $clog2(MAX_SEGMENTS);
  localparam int SEG_CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int REC_IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int REC_CNT_W = $clog2(MAX_RECORDS + 1);

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OOM    = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_BADPTR = 2'd3;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic CFG_BASE   = 1'b0;
  localparam logic CFG_LENGTH = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [23:0] request_size;
    logic [3:0]  align_log2;
    logic [31:0] free_address;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] grant_addr;
    logic [31:0] granted_size;
    logic [5:0]  live_count;
    logic [31:0] live_bytes;
  } result_t;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } seg_t;

  typedef enum logic [2:0] {
    SEG_HOLD,
    SEG_LOAD,
    SEG_WRITE,
    SEG_SHL,
    SEG_SHR
  } seg_op_t;

  typedef struct packed {
    seg_op_t              op;
    logic [SEG_IDX_W-1:0] pos;
    seg_t                 wr;
  } seg_cmd_t;

endpackage

[rtl/core/ffca_seg_cell.sv]
// One free-segment entry of the chain; shifts with its neighbors on insert/remove.
// Depends on ffca_pkg.
module ffca_seg_cell import ffca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SEG_IDX_W-1:0] idx,
  input  seg_cmd_t             cmd,
  input  seg_t                 left_in,
  input  seg_t                 right_in,
  output seg_t                 q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else begin
      case (cmd.op)
        SEG_LOAD: begin
          q <= (idx == '0) ? cmd.wr : '0;
        end
        SEG_WRITE: begin
          if (idx == cmd.pos) q <= cmd.wr;
        end
        SEG_SHL: begin
          if (idx >= cmd.pos) q <= right_in;
        end
        SEG_SHR: begin
          if (idx == cmd.pos) q <= cmd.wr;
          else if (idx > cmd.pos) q <= left_in;
        end
        default: begin
          q <= q;
        end
      endcase
    end
  end

endmodule

[rtl/core/ffca_seg_chain.sv]
// Row of segment cells kept in address order, with one indexed read port.
// Depends on ffca_pkg and ffca_seg_cell.
module ffca_seg_chain import ffca_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  seg_cmd_t             cmd,
  input  logic [SEG_IDX_W-1:0] rd_idx,
  output seg_t                 rd_data
);

  seg_t cell_q [MAX_SEGMENTS];

  for (genvar k = 0; k < MAX_SEGMENTS; k++) begin : g_cell
    seg_t left_in;
    seg_t right_in;
    if (k == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_q[k-1];
    end
    if (k == MAX_SEGMENTS - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_q[k+1];
    end
    ffca_seg_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (SEG_IDX_W'(k)),
      .cmd      (cmd),
      .left_in  (left_in),
      .right_in (right_in),
      .q        (cell_q[k])
    );
  end

  assign rd_data = cell_q[rd_idx];

endmodule

[rtl/core/first_fit_coalescing_allocator_top.sv]
// Top level of the first-fit coalescing allocator: sequencer, record table, counters.
// Depends on ffca_pkg and ffca_seg_chain.
//
// One request is taken at a time: busy is high from the accepting edge until the result
// strobe. An allocate walks the chain entries up to and including the first fit (or all of
// them when nothing fits), then the records up to and including the first free one, then
// computes and applies the grant; a free walks the records up to the match, then the chain
// entries up to and including the insert point, then applies the merge, with an extra
// shift step when it merges on both sides. Each result is shown for one cycle on done and
// result and cannot be stalled. Configuration writes are taken while busy is low.
module first_fit_coalescing_allocator_top import ffca_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  request_t    request,
  output logic        busy,
  output logic        done,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ASCAN  = 9'b000000010,
    S_AREC   = 9'b000000100,
    S_ACALC  = 9'b000001000,
    S_AAPPLY = 9'b000010000,
    S_FREC   = 9'b000100000,
    S_FPOS   = 9'b001000000,
    S_FAPPLY = 9'b010000000,
    S_FSHIFT = 9'b100000000
  } state_t;

  state_t               state;
  request_t             req;
  logic [31:0]          base;
  logic [SEG_CNT_W-1:0] seg_count;
  logic [SEG_CNT_W-1:0] idx;
  logic [REC_IDX_W-1:0] rec_idx;
  logic [REC_IDX_W-1:0] rec_sel;
  logic [REC_CNT_W-1:0] active_count;
  logic [31:0]          active_bytes;

  logic [31:0] rec_payload [MAX_RECORDS];
  logic [31:0] rec_bstart  [MAX_RECORDS];
  logic [31:0] rec_blen    [MAX_RECORDS];
  logic [MAX_RECORDS-1:0] rec_valid;

  logic [31:0]          b_start;
  logic [31:0]          b_len;
  logic [15:0]          pad;
  logic [SEG_CNT_W-1:0] pos;
  logic [32:0]          pay;
  logic [32:0]          bend;
  logic [31:0]          space;
  seg_t                 prev;
  seg_t                 nbr;
  logic                 left_m;
  logic                 right_m;
  logic [31:0]          f_pay;

  seg_cmd_t seg_cmd;
  seg_t     cur;

  logic        cfg_fire;
  logic [32:0] cfg_sum;
  logic [31:0] clip_len;
  logic [15:0] sum_h;
  logic [15:0] amask;
  logic [15:0] pad_c;
  logic        fit;
  logic [33:0] pend;
  logic [33:0] split;
  logic [33:0] tail;
  logic        do_split;
  logic [31:0] f_bytes;
  logic        pos_hit;

  ffca_seg_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .cmd     (seg_cmd),
    .rd_idx  (idx[SEG_IDX_W-1:0]),
    .rd_data (cur)
  );

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign cfg_fire  = cfg_valid && cfg_ready;

  assign cfg_sum  = {1'b0, base} + {1'b0, cfg_data};
  assign clip_len = (cfg_sum[32] && (cfg_sum[31:0] != '0)) ? (32'd0 - base) : cfg_data;

  assign sum_h = cur.start[15:0] + 16'(HEADER_BYTES);
  assign amask = ((16'd1 << req.align_log2) - 16'd1) | 16'(HEADER_ALIGN - 1);
  assign pad_c = (16'd0 - sum_h) & amask;
  assign fit   = (34'(req.request_size) + 34'(HEADER_BYTES) + 34'(pad_c)) <= 34'(cur.len);

  assign pend     = 34'(pay) + 34'(req.request_size);
  assign split    = (pend + 34'(SEGMENT_ALIGN - 1)) & ~34'(SEGMENT_ALIGN - 1);
  assign tail     = 34'(bend) - split;
  assign do_split = (split <= 34'(bend)) && (tail >= 34'(MIN_SEGMENT_BYTES));

  assign f_bytes = b_len - (f_pay - b_start);
  assign pos_hit = (idx == seg_count) || (cur.start >= b_start);

  always_comb begin
    seg_cmd    = '0;
    seg_cmd.op = SEG_HOLD;
    if (cfg_fire && cfg_index == CFG_LENGTH) begin
      seg_cmd.op       = SEG_LOAD;
      seg_cmd.wr.start = base;
      seg_cmd.wr.len   = clip_len;
    end else begin
      case (state)
        S_AAPPLY: begin
          seg_cmd.pos = pos[SEG_IDX_W-1:0];
          if (do_split) begin
            seg_cmd.op       = SEG_WRITE;
            seg_cmd.wr.start = split[31:0];
            seg_cmd.wr.len   = tail[31:0];
          end else begin
            seg_cmd.op = SEG_SHL;
          end
        end
        S_FAPPLY: begin
          if (left_m) begin
            seg_cmd.op       = SEG_WRITE;
            seg_cmd.pos      = SEG_IDX_W'(pos - SEG_CNT_W'(1));
            seg_cmd.wr.start = prev.start;
            seg_cmd.wr.len   = right_m ? (prev.len + b_len + nbr.len) : (prev.len + b_len);
          end else if (right_m) begin
            seg_cmd.op       = SEG_WRITE;
            seg_cmd.pos      = pos[SEG_IDX_W-1:0];
            seg_cmd.wr.start = b_start;
            seg_cmd.wr.len   = nbr.len + b_len;
          end else if (seg_count < SEG_CNT_W'(MAX_SEGMENTS)) begin
            seg_cmd.op       = SEG_SHR;
            seg_cmd.pos      = pos[SEG_IDX_W-1:0];
            seg_cmd.wr.start = b_start;
            seg_cmd.wr.len   = b_len;
          end
        end
        S_FSHIFT: begin
          seg_cmd.op  = SEG_SHL;
          seg_cmd.pos = pos[SEG_IDX_W-1:0];
        end
        default: begin
          seg_cmd.op = SEG_HOLD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      done         <= 1'b0;
      base         <= '0;
      seg_count    <= SEG_CNT_W'(1);
      rec_valid    <= '0;
      active_count <= '0;
      active_bytes <= '0;
      idx          <= '0;
      rec_idx      <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_fire) begin
        if (cfg_index == CFG_BASE) begin
          base <= cfg_data;
        end else begin
          seg_count    <= SEG_CNT_W'(1);
          rec_valid    <= '0;
          active_count <= '0;
          active_bytes <= '0;
        end
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            req     <= request;
            idx     <= '0;
            rec_idx <= '0;
            prev    <= '0;
            state   <= (request.mode == MODE_FREE) ? S_FREC : S_ASCAN;
          end
        end
        S_ASCAN: begin
          if (idx == seg_count) begin
            result <= '{ST_OOM, 32'd0, 32'd0, 6'(active_count), active_bytes};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (fit) begin
            b_start <= cur.start;
            b_len   <= cur.len;
            pad     <= pad_c;
            pos     <= idx;
            state   <= S_AREC;
          end else begin
            idx <= idx + SEG_CNT_W'(1);
          end
        end
        S_AREC: begin
          if (!rec_valid[rec_idx]) begin
            rec_sel <= rec_idx;
            state   <= S_ACALC;
          end else if (rec_idx == REC_IDX_W'(MAX_RECORDS - 1)) begin
            result <= '{ST_FULL, 32'd0, 32'd0, 6'(active_count), active_bytes};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            rec_idx <= rec_idx + REC_IDX_W'(1);
          end
        end
        S_ACALC: begin
          pay   <= {1'b0, b_start} + 33'(pad) + 33'(HEADER_BYTES);
          bend  <= {1'b0, b_start} + {1'b0, b_len};
          space <= b_len - 32'(HEADER_BYTES) - 32'(pad);
          state <= S_AAPPLY;
        end
        S_AAPPLY: begin
          rec_valid[rec_sel]   <= 1'b1;
          rec_payload[rec_sel] <= pay[31:0];
          rec_bstart[rec_sel]  <= b_start;
          active_count         <= active_count + REC_CNT_W'(1);
          if (do_split) begin
            rec_blen[rec_sel] <= b_len - tail[31:0];
            active_bytes      <= active_bytes + (space - tail[31:0]);
            result <= '{ST_OK, pay[31:0], space - tail[31:0], 6'(active_count + REC_CNT_W'(1)),
                        active_bytes + (space - tail[31:0])};
          end else begin
            rec_blen[rec_sel] <= b_len;
            seg_count         <= seg_count - SEG_CNT_W'(1);
            active_bytes      <= active_bytes + space;
            result <= '{ST_OK, pay[31:0], space, 6'(active_count + REC_CNT_W'(1)),
                        active_bytes + space};
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_FREC: begin
          if (rec_valid[rec_idx] && rec_payload[rec_idx] == req.free_address) begin
            rec_sel <= rec_idx;
            b_start <= rec_bstart[rec_idx];
            b_len   <= rec_blen[rec_idx];
            f_pay   <= rec_payload[rec_idx];
            state   <= S_FPOS;
          end else if (rec_idx == REC_IDX_W'(MAX_RECORDS - 1)) begin
            result <= '{ST_BADPTR, 32'd0, 32'd0, 6'(active_count), active_bytes};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            rec_idx <= rec_idx + REC_IDX_W'(1);
          end
        end
        S_FPOS: begin
          if (pos_hit) begin
            pos     <= idx;
            nbr     <= cur;
            left_m  <= (idx != '0) &&
                       (({1'b0, prev.start} + {1'b0, prev.len}) == {1'b0, b_start});
            right_m <= (idx != seg_count) &&
                       (({1'b0, b_start} + {1'b0, b_len}) == {1'b0, cur.start});
            state   <= S_FAPPLY;
          end else begin
            prev <= cur;
            idx  <= idx + SEG_CNT_W'(1);
          end
        end
        S_FAPPLY: begin
          if (left_m && right_m) begin
            state <= S_FSHIFT;
          end else if (!left_m && !right_m && seg_count >= SEG_CNT_W'(MAX_SEGMENTS)) begin
            result <= '{ST_FULL, 32'd0, 32'd0, 6'(active_count), active_bytes};
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            if (!left_m && !right_m) seg_count <= seg_count + SEG_CNT_W'(1);
            rec_valid[rec_sel] <= 1'b0;
            active_count       <= active_count - REC_CNT_W'(1);
            active_bytes       <= active_bytes - f_bytes;
            result <= '{ST_OK, 32'd0, 32'd0, 6'(active_count - REC_CNT_W'(1)),
                        active_bytes - f_bytes};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        S_FSHIFT: begin
          seg_count          <= seg_count - SEG_CNT_W'(1);
          rec_valid[rec_sel] <= 1'b0;
          active_count       <= active_count - REC_CNT_W'(1);
          active_bytes       <= active_bytes - f_bytes;
          result <= '{ST_OK, 32'd0, 32'd0, 6'(active_count - REC_CNT_W'(1)),
                      active_bytes - f_bytes};
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still busy");
  a_start_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");
  a_seg_count: assert property (@(posedge clk) disable iff (rst)
    seg_count <= SEG_CNT_W'(MAX_SEGMENTS))
    else $error("segment count out of range");
  a_live_count: assert property (@(posedge clk) disable iff (rst)
    active_count == REC_CNT_W'($countones(rec_valid)))
    else $error("live count disagrees with record table");

endmodule

[verif/tb.sv]
// Self-checking testbench for first_fit_coalescing_allocator_top: directed and random
// allocate/free traffic with buffer reconfiguration, checked against an in-bench predictor.
// Depends on ffca_pkg and the allocator RTL.
module tb import ffca_pkg::*;;

  typedef enum logic [1:0] {
    PLAN_REQ,
    PLAN_CFG,
    PLAN_DRAIN
  } plan_kind_t;

  typedef struct {
    plan_kind_t  kind;
    request_t    req;
    bit          pick_live;
    logic        cfg_index;
    logic [31:0] cfg_data;
  } plan_item_t;

  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst;
  logic        start;
  request_t    request;
  logic        busy;
  logic        done;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  plan_item_t  plan_q[$];
  result_t     pending_results[$];

  seg_t        free_segs[$];
  logic [31:0] heap_base;
  logic [31:0] heap_length;
  logic [31:0] rec_payload [MAX_RECORDS];
  logic [31:0] rec_start [MAX_RECORDS];
  logic [31:0] rec_length [MAX_RECORDS];
  bit          rec_used [MAX_RECORDS];
  logic [5:0]  held_count;
  logic [31:0] held_bytes;

  int          errors;
  int          cycles;
  int          gap_left;
  int          settle;
  int          no_idle_left;
  int          status_seen [4];
  int          cfg_writes;

  first_fit_coalescing_allocator_top dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .done     (done),
    .result   (result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint unsigned pad_up(longint unsigned a, longint unsigned al);
    longint unsigned r;
    r = a % al;
    return (r != 0) ? al - r : 0;
  endfunction

  function automatic void rebuild_heap();
    longint unsigned len;
    longint unsigned room;
    len = heap_length;
    room = 64'h1_0000_0000 - longint'(heap_base);
    if (len > room) len = room;
    free_segs.delete();
    free_segs.push_back('{start: heap_base, len: len[31:0]});
    for (int i = 0; i < MAX_RECORDS; i++) begin
      rec_used[i] = 1'b0;
      rec_payload[i] = '0;
      rec_start[i] = '0;
      rec_length[i] = '0;
    end
    held_count = '0;
    held_bytes = '0;
  endfunction

  function automatic void apply_cfg(logic idx, logic [31:0] data);
    if (idx == CFG_BASE) begin
      heap_base = data;
    end else begin
      heap_length = data;
      rebuild_heap();
    end
  endfunction

  function automatic bit return_range(logic [31:0] s, logic [31:0] l);
    int pos;
    bit lft;
    bit rgt;
    pos = 0;
    while (pos < free_segs.size() && free_segs[pos].start < s) pos++;
    lft = pos > 0 && longint'(free_segs[pos-1].start) + longint'(free_segs[pos-1].len)
          == longint'(s);
    rgt = pos < free_segs.size() && longint'(s) + longint'(l) == longint'(free_segs[pos].start);
    if (lft && rgt) begin
      free_segs[pos-1].len = free_segs[pos-1].len + l + free_segs[pos].len;
      free_segs.delete(pos);
    end else if (lft) begin
      free_segs[pos-1].len = free_segs[pos-1].len + l;
    end else if (rgt) begin
      free_segs[pos].start = s;
      free_segs[pos].len = free_segs[pos].len + l;
    end else begin
      if (free_segs.size() >= MAX_SEGMENTS) return 1'b0;
      free_segs.insert(pos, '{start: s, len: l});
    end
    return 1'b1;
  endfunction

  function automatic result_t predict_allocation(request_t rq);
    result_t r;
    longint unsigned want, al, pad, p, bstart, blen, bend, pay, space, pend, split, tail;
    int seg;
    int rec;
    r = '0;
    want = rq.request_size;
    al = 64'd1 << rq.align_log2;
    if (al < HEADER_ALIGN) al = HEADER_ALIGN;
    seg = -1;
    rec = -1;
    pad = 0;
    for (int i = 0; i < free_segs.size(); i++) begin
      p = pad_up(longint'(free_segs[i].start) + HEADER_BYTES, al);
      if (want + HEADER_BYTES + p <= longint'(free_segs[i].len)) begin
        seg = i;
        pad = p;
        break;
      end
    end
    for (int i = 0; i < MAX_RECORDS; i++) begin
      if (!rec_used[i]) begin
        rec = i;
        break;
      end
    end
    if (seg < 0) begin
      r.status = ST_OOM;
    end else if (rec < 0) begin
      r.status = ST_FULL;
    end else begin
      bstart = free_segs[seg].start;
      blen = free_segs[seg].len;
      bend = bstart + blen;
      pay = bstart + pad + HEADER_BYTES;
      space = blen - HEADER_BYTES - pad;
      pend = pay + want;
      split = pend + pad_up(pend, SEGMENT_ALIGN);
      free_segs.delete(seg);
      if (split <= bend && bend - split >= MIN_SEGMENT_BYTES) begin
        tail = bend - split;
        space -= tail;
        blen -= tail;
        void'(return_range(split[31:0], tail[31:0]));
      end
      rec_used[rec] = 1'b1;
      rec_payload[rec] = pay[31:0];
      rec_start[rec] = bstart[31:0];
      rec_length[rec] = blen[31:0];
      held_count = held_count + 6'd1;
      held_bytes = held_bytes + space[31:0];
      r.status = ST_OK;
      r.grant_addr = pay[31:0];
      r.granted_size = space[31:0];
    end
    r.live_count = held_count;
    r.live_bytes = held_bytes;
    return r;
  endfunction

  function automatic result_t predict_release(request_t rq);
    result_t r;
    int rec;
    r = '0;
    rec = -1;
    for (int i = 0; i < MAX_RECORDS; i++) begin
      if (rec_used[i] && rec_payload[i] == rq.free_address) begin
        rec = i;
        break;
      end
    end
    if (rec < 0) begin
      r.status = ST_BADPTR;
    end else if (!return_range(rec_start[rec], rec_length[rec])) begin
      r.status = ST_FULL;
    end else begin
      rec_used[rec] = 1'b0;
      held_count = held_count - 6'd1;
      held_bytes = held_bytes - (rec_length[rec] - (rec_payload[rec] - rec_start[rec]));
      r.status = ST_OK;
    end
    r.live_count = held_count;
    r.live_bytes = held_bytes;
    return r;
  endfunction

  function automatic logic [31:0] live_payload();
    int idx[$];
    for (int i = 0; i < MAX_RECORDS; i++) begin
      if (rec_used[i]) idx.push_back(i);
    end
    if (idx.size() == 0) return $urandom();
    return rec_payload[idx[$urandom_range(0, idx.size() - 1)]];
  endfunction

  function automatic void plan_alloc(int unsigned sz, int unsigned al);
    plan_item_t it;
    it = '{kind: PLAN_REQ, req: '0, pick_live: 1'b0, cfg_index: CFG_BASE, cfg_data: '0};
    it.req.mode = MODE_ALLOC;
    it.req.request_size = sz[23:0];
    it.req.align_log2 = al[3:0];
    it.req.free_address = $urandom();
    plan_q.push_back(it);
  endfunction

  function automatic void plan_free(logic [31:0] addr, bit live);
    plan_item_t it;
    it = '{kind: PLAN_REQ, req: '0, pick_live: live, cfg_index: CFG_BASE, cfg_data: '0};
    it.req.mode = MODE_FREE;
    it.req.request_size = $urandom();
    it.req.align_log2 = $urandom();
    it.req.free_address = addr;
    plan_q.push_back(it);
  endfunction

  function automatic void plan_cfg(logic idx, logic [31:0] data);
    plan_q.push_back('{kind: PLAN_CFG, req: '0, pick_live: 1'b0, cfg_index: idx,
                       cfg_data: data});
  endfunction

  function automatic void plan_drain();
    plan_q.push_back('{kind: PLAN_DRAIN, req: '0, pick_live: 1'b0, cfg_index: CFG_BASE,
                       cfg_data: '0});
  endfunction

  function automatic void plan_random_phase(int n);
    int unsigned pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 9))
          0:       plan_alloc($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 15));
          1:       plan_alloc($urandom_range(0, 4000), $urandom_range(0, 15));
          default: plan_alloc($urandom_range(0, 300), $urandom_range(0, 6));
        endcase
      end else if (pick < 90) begin
        plan_free('0, 1'b1);
      end else begin
        plan_free($urandom(), 1'b0);
      end
    end
  endfunction

  task automatic check_field(string name, longint unsigned exp, longint unsigned act);
    if (exp != act) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp, act);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    plan_item_t it;
    request_t rq;
    logic next_start;
    logic next_cfg;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      request <= '0;
      cfg_index <= CFG_BASE;
      cfg_data <= '0;
      gap_left <= 0;
      settle <= 0;
      no_idle_left <= 0;
    end else begin
      if (start && !busy) begin
        pending_results.push_back(request.mode == MODE_ALLOC ? predict_allocation(request)
                                                             : predict_release(request));
      end
      if (cfg_valid && cfg_ready) begin
        apply_cfg(cfg_index, cfg_data);
        cfg_writes++;
      end
      next_start = start && busy;
      next_cfg = cfg_valid && !cfg_ready;
      if (busy || pending_results.size() != 0 || next_start || (start && !busy)) settle <= 0;
      else settle <= settle + 1;
      if (!next_start && !next_cfg && !(start && !busy) && !(cfg_valid && cfg_ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (plan_q.size() != 0) begin
          it = plan_q[0];
          case (it.kind)
            PLAN_REQ: begin
              rq = it.req;
              if (it.pick_live) rq.free_address = live_payload();
              request <= rq;
              next_start = 1'b1;
              void'(plan_q.pop_front());
              if (no_idle_left > 0) begin
                no_idle_left <= no_idle_left - 1;
                gap_left <= 0;
              end else begin
                if ($urandom_range(0, 29) == 0) no_idle_left <= $urandom_range(10, 40);
                gap_left <= $urandom_range(0, 14);
              end
            end
            PLAN_CFG: begin
              if (pending_results.size() == 0 && !busy && settle >= 8) begin
                cfg_index <= it.cfg_index;
                cfg_data <= it.cfg_data;
                next_cfg = 1'b1;
                void'(plan_q.pop_front());
              end
            end
            default: begin
              if (pending_results.size() == 0 && !busy) void'(plan_q.pop_front());
            end
          endcase
        end
      end
      start <= next_start;
      cfg_valid <= next_cfg;
    end
  end

  always @(posedge clk) begin
    result_t exp;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no expectation waiting");
        errors++;
      end else begin
        exp = pending_results.pop_front();
        status_seen[exp.status]++;
        check_field("status", exp.status, result.status);
        check_field("grant_addr", exp.grant_addr, result.grant_addr);
        check_field("granted_size", exp.granted_size, result.granted_size);
        check_field("live_count", exp.live_count, result.live_count);
        check_field("live_bytes", exp.live_bytes, result.live_bytes);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    request = '0;
    cfg_index = CFG_BASE;
    cfg_data = '0;
    errors = 0;
    cycles = 0;
    cfg_writes = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    heap_base = '0;
    heap_length = '0;
    rebuild_heap();

    plan_alloc(16, 0);
    plan_free(32'h0, 1'b0);
    plan_cfg(CFG_BASE, 32'h0000_1000);
    plan_cfg(CFG_LENGTH, 32'h0000_1000);
    plan_alloc(0, 0);
    plan_alloc(100, 3);
    plan_alloc(24'hFFFFFF, 0);
    plan_alloc(40, 12);
    plan_alloc(1, 15);
    plan_free(32'hDEAD_BEEF, 1'b0);
    plan_free(32'h0000_1010, 1'b0);
    plan_free(32'h0000_1010, 1'b0);
    plan_alloc(3000, 0);
    plan_alloc(8, 4);
    plan_free('0, 1'b1);
    plan_free('0, 1'b1);
    plan_free('0, 1'b1);
    plan_drain();
    plan_cfg(CFG_BASE, 32'hFFFF_F000);
    plan_cfg(CFG_LENGTH, 32'hFFFF_FFFF);
    plan_alloc(64, 0);
    plan_alloc(4000, 0);
    plan_free(32'hFFFF_FFFF, 1'b0);
    plan_free('0, 1'b1);
    plan_cfg(CFG_BASE, 32'h0);
    plan_cfg(CFG_LENGTH, 32'h0001_0000);
    for (int k = 0; k < 33; k++) plan_alloc($urandom_range(0, 40), 0);
    for (int k = 0; k < 20; k++) plan_free('0, 1'b1);
    for (int k = 0; k < 10; k++) plan_alloc($urandom_range(0, 100), $urandom_range(0, 5));
    plan_drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: plan_cfg(CFG_BASE, 32'hFFFF_FFFF);
        1: plan_cfg(CFG_BASE, 32'h0);
        default: plan_cfg(CFG_BASE, $urandom());
      endcase
      case (ph)
        0: plan_cfg(CFG_LENGTH, 32'd1);
        1: plan_cfg(CFG_LENGTH, 32'd0);
        2: plan_cfg(CFG_LENGTH, 32'hFFFF_FFFF);
        default: plan_cfg(CFG_LENGTH, $urandom_range(64, 8192));
      endcase
      plan_random_phase(ph < 2 ? 10 : 60);
      if (ph == 4) plan_drain();
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (plan_q.size() == 0 && pending_results.size() == 0 && !start);
    repeat (100) @(posedge clk);
    $display("Checked %0d ok, %0d out-of-memory, %0d table-full, %0d bad-pointer results",
             status_seen[ST_OK], status_seen[ST_OOM], status_seen[ST_FULL],
             status_seen[ST_BADPTR]);
    $display("across %0d buffer register writes", cfg_writes);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
